FILE: rtl/gprsr_pkg.sv
// ----------------------------------------------------------------------------
// Gamepad replay package
// Shared constants, item codes and types for the gamepad replay block.
// ----------------------------------------------------------------------------
package gprsr_pkg;

   localparam int unsigned TABLE_DEPTH = 65536;
   localparam int unsigned TABLE_AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   localparam int unsigned WORD_W   = 32;
   localparam int unsigned BUTTON_W = 8;
   localparam int unsigned COUNT_W  = $clog2(WORD_W);

   localparam logic [1:0] KIND_LATCH = 2'd0;
   localparam logic [1:0] KIND_CLOCK = 2'd1;
   localparam logic [1:0] KIND_POWER = 2'd2;
   localparam logic [1:0] KIND_LOAD  = 2'd3;

   localparam logic CSR_SHORT_GAP_LIMIT = 1'b0;
   localparam logic CSR_FRAME_PERIOD    = 1'b1;

   localparam logic [WORD_W-1:0] SHORT_GAP_RESET    = 32'd1000;
   localparam logic [WORD_W-1:0] FRAME_PERIOD_RESET = 32'd33260;
   localparam logic [WORD_W-1:0] FRAME_START        = '1;
   localparam logic [7:0]        LATCH_MAX          = 8'd255;

   typedef struct packed {
      logic              done;
      logic [WORD_W-1:0] quotient;
   } div_result_type;

endpackage

FILE: rtl/gprsr_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module gprsr_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 256
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic                                        rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/gprsr_div.sv
// ----------------------------------------------------------------------------
// Gap divider
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gprsr_div
   import gprsr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [WORD_W-1:0]    dividend,
   input  logic [WORD_W-1:0]    divisor,
   output div_result_type       result
);

   logic               busy_ff,    busy_in;
   logic               done_ff,    done_in;
   logic [COUNT_W-1:0] count_ff,   count_in;
   logic [WORD_W-1:0]  rem_ff,     rem_in;
   logic [WORD_W-1:0]  quo_ff,     quo_in;
   logic [WORD_W-1:0]  divisor_ff, divisor_in;
   logic [WORD_W:0]    shifted;
   logic [WORD_W:0]    diff;

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      shifted    = {rem_ff, quo_ff[WORD_W-1]};
      diff       = shifted - {1'b0, divisor_ff};
      if (start) begin
         busy_in    = 1'b1;
         count_in   = '0;
         rem_in     = '0;
         quo_in     = dividend;
         divisor_in = divisor;
      end else if (busy_ff) begin
         if (!diff[WORD_W]) begin
            rem_in = diff[WORD_W-1:0];
            quo_in = {quo_ff[WORD_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[WORD_W-1:0];
            quo_in = {quo_ff[WORD_W-2:0], 1'b0};
         end
         count_in = count_ff + 1'b1;
         if (count_ff == COUNT_W'(WORD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff   <= count_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
   end

   assign result.done     = done_ff;
   assign result.quotient = quo_ff;

endmodule

FILE: rtl/gamepad_replay_shift_register.sv
// ----------------------------------------------------------------------------
// Gamepad replay shift register
// Replays recorded button bytes to a console as a serial controller.
// ----------------------------------------------------------------------------
// Input items (latch, clock, power change, table load) arrive on the req_
// channel and each gives exactly one result on the rsp_ channel: the data line
// level, the frame counter and the latch count after the item.
// The block takes one item at a time and stalls its input until the result of
// that item has been registered. A clock, power or load item goes straight to
// the done state, where its result is registered. A latch passes the latch and
// load states, and a read-wait state when it reads the button table. A latch
// whose gap is at least the short-gap limit and one frame period divides it by
// the period in the divider, one quotient bit per cycle, the worst-case path.
// The result register lets the next item enter while a result waits; if the
// receiver stalls, the following result waits in the sequencer until the
// result register is free.
// Reset sets the CSRs to their defaults, clears the latch count, sets the frame
// counter to all ones, stops the block and clears the internal data level. The
// button table keeps no reset value and holds its contents only once loaded.
// ----------------------------------------------------------------------------
module gamepad_replay_shift_register
   import gprsr_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_kind,
   input  logic [WORD_W-1:0]   req_gap_time,
   input  logic                req_power_level,
   input  logic [15:0]         req_load_index,
   input  logic [BUTTON_W-1:0] req_load_value,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_data_line,
   output logic [WORD_W-1:0]   rsp_frame_number,
   output logic [7:0]          rsp_latch_number,
   input  logic                csr_write_enable,
   input  logic                csr_index,
   input  logic [WORD_W-1:0]   csr_write_data
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_LATCH  = 3'd1;
   localparam logic [2:0] S_DIV    = 3'd2;
   localparam logic [2:0] S_LOAD   = 3'd3;
   localparam logic [2:0] S_RDWAIT = 3'd4;
   localparam logic [2:0] S_DONE   = 3'd5;

   logic [2:0]          state_ff,       state_in;
   logic [WORD_W-1:0]   short_limit_ff, short_limit_in;
   logic [WORD_W-1:0]   period_ff,      period_in;
   logic [7:0]          repeat_ff,      repeat_in;
   logic [WORD_W-1:0]   frame_ff,       frame_in;
   logic [BUTTON_W-1:0] shift_ff,       shift_in;
   logic                running_ff,     running_in;
   logic                pin_ff,         pin_in;
   logic [WORD_W-1:0]   gap_ff,         gap_in;
   logic                oob_ff,         oob_in;
   logic                rsp_valid_ff,   rsp_valid_in;
   logic                rsp_pin_ff,     rsp_pin_in;
   logic [WORD_W-1:0]   rsp_frame_ff,   rsp_frame_in;
   logic [7:0]          rsp_latch_ff,   rsp_latch_in;

   logic                req_transfer;
   logic                div_start;
   logic [WORD_W-1:0]   div_divisor;
   div_result_type      div_result;
   logic                ram_wr_en;
   logic [WORD_W-1:0]   load_index_wide;
   logic                ram_rd_en;
   logic [BUTTON_W-1:0] ram_rd_data;
   logic [BUTTON_W-1:0] loaded_byte;

   assign req_transfer    = req_valid && !req_stall;
   assign req_stall       = (state_ff != S_IDLE);
   assign load_index_wide = WORD_W'(req_load_index);
   assign ram_wr_en       = req_transfer && (req_kind == KIND_LOAD)
                            && (load_index_wide < WORD_W'(TABLE_DEPTH));
   assign div_divisor     = (period_ff == '0) ? WORD_W'(1) : period_ff;
   assign loaded_byte     = oob_ff ? '0 : ram_rd_data;

   always_comb begin
      state_in       = state_ff;
      short_limit_in = short_limit_ff;
      period_in      = period_ff;
      repeat_in      = repeat_ff;
      frame_in       = frame_ff;
      shift_in       = shift_ff;
      running_in     = running_ff;
      pin_in         = pin_ff;
      gap_in         = gap_ff;
      oob_in         = oob_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_pin_in     = rsp_pin_ff;
      rsp_frame_in   = rsp_frame_ff;
      rsp_latch_in   = rsp_latch_ff;
      div_start      = 1'b0;
      ram_rd_en      = 1'b0;

      if (csr_write_enable) begin
         case (csr_index)
            CSR_SHORT_GAP_LIMIT: short_limit_in = csr_write_data;
            CSR_FRAME_PERIOD:    period_in      = csr_write_data;
            default: ;
         endcase
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_transfer) begin
               state_in = S_DONE;
               case (req_kind)
                  KIND_LATCH: begin
                     gap_in   = req_gap_time;
                     state_in = S_LATCH;
                  end
                  KIND_CLOCK: begin
                     if (running_ff) begin
                        pin_in   = ~shift_ff[0];
                        shift_in = shift_ff >> 1;
                     end
                  end
                  KIND_POWER: begin
                     if (req_power_level) begin
                        repeat_in  = '0;
                        frame_in   = FRAME_START;
                        shift_in   = '0;
                        running_in = 1'b1;
                     end else begin
                        running_in = 1'b0;
                        pin_in     = 1'b0;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_LATCH: begin
            state_in = S_LOAD;
            if (gap_ff < short_limit_ff) begin
               if (repeat_ff != LATCH_MAX) begin
                  repeat_in = repeat_ff + 8'd1;
               end
            end else if (gap_ff < period_ff) begin
               repeat_in = '0;
               frame_in  = frame_ff + WORD_W'(1);
            end else begin
               repeat_in = '0;
               div_start = 1'b1;
               state_in  = S_DIV;
            end
         end
         S_DIV: begin
            if (div_result.done) begin
               frame_in = frame_ff + div_result.quotient;
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            state_in = S_DONE;
            if (repeat_ff inside {[8'd0:8'd1]}) begin
               pin_in   = 1'b1;
               shift_in = '0;
            end else if (repeat_ff inside {[8'd2:8'd3]}) begin
               ram_rd_en = 1'b1;
               oob_in    = !(frame_ff < WORD_W'(TABLE_DEPTH));
               state_in  = S_RDWAIT;
            end else begin
               pin_in   = ~shift_ff[0];
               shift_in = shift_ff >> 1;
            end
         end
         S_RDWAIT: begin
            pin_in   = ~loaded_byte[0];
            shift_in = loaded_byte >> 1;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_pin_in   = pin_ff;
               rsp_frame_in = frame_ff;
               rsp_latch_in = repeat_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         short_limit_ff <= SHORT_GAP_RESET;
         period_ff      <= FRAME_PERIOD_RESET;
         repeat_ff      <= '0;
         frame_ff       <= FRAME_START;
         shift_ff       <= '0;
         running_ff     <= 1'b0;
         pin_ff         <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         short_limit_ff <= short_limit_in;
         period_ff      <= period_in;
         repeat_ff      <= repeat_in;
         frame_ff       <= frame_in;
         shift_ff       <= shift_in;
         running_ff     <= running_in;
         pin_ff         <= pin_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      gap_ff       <= gap_in;
      oob_ff       <= oob_in;
      rsp_pin_ff   <= rsp_pin_in;
      rsp_frame_ff <= rsp_frame_in;
      rsp_latch_ff <= rsp_latch_in;
   end

   gprsr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (gap_ff),
      .divisor  (div_divisor),
      .result   (div_result)
   );

   gprsr_ram #(
      .WIDTH (BUTTON_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (load_index_wide[TABLE_AW-1:0]),
      .wr_data (req_load_value),
      .rd_en   (ram_rd_en),
      .rd_addr (frame_ff[TABLE_AW-1:0]),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_data_line    = rsp_pin_ff;
   assign rsp_frame_number = rsp_frame_ff;
   assign rsp_latch_number = rsp_latch_ff;

endmodule

FILE: rtl/gprsr_checker.sv
// ----------------------------------------------------------------------------
// Gamepad replay checker
// Port-level assertions for the gamepad replay block, bound to the top level.
// ----------------------------------------------------------------------------
module gprsr_checker
   import gprsr_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_stall,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic                rsp_data_line,
   input logic [WORD_W-1:0]   rsp_frame_number,
   input logic [7:0]          rsp_latch_number
);

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data_line)
         && $stable(rsp_frame_number) && $stable(rsp_latch_number))
      else $error("A stalled result changed before its transfer.");

   a_busy_after_transfer : assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("The input was free in the cycle after a transfer.");

   a_result_follows_work : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("A result appeared without an item in progress.");

   a_reset_state : assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("The block did not come out of reset idle.");

endmodule

bind gamepad_replay_shift_register gprsr_checker u_checker (.*);
